// ----- design/asss_pkg.sv -----
package asss_pkg;

    localparam int MAX_SITES = 4096;
    localparam int SITE_W    = $clog2(MAX_SITES);
    localparam int CNT_W     = SITE_W + 1;

    // action codes
    localparam logic [2:0] ACT_MARK   = 3'd0;
    localparam logic [2:0] ACT_UNMARK = 3'd1;
    localparam logic [2:0] ACT_SETDEG = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // status codes
    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_SITE_OR = 2'd1;
    localparam logic [1:0] STS_POS_OR  = 2'd2;

    // configuration register indexes
    localparam logic CFG_SITE_COUNT = 1'b0;
    localparam logic CFG_BULK_THR   = 1'b1;

    localparam logic [CNT_W-1:0] SITE_COUNT_RST = CNT_W'(MAX_SITES);
    localparam logic [7:0]       BULK_THR_RST   = 8'd12;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] site;
        logic [7:0]  degree;
        logic [11:0] position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        site_active;
        logic        site_static;
        logic [12:0] active_count;
        logic [11:0] listed_site;
    } t_rsp;

    // one per-site memory word: bitmap flags plus reverse map
    typedef struct packed {
        logic              active;
        logic              stat_flag;
        logic              listed;
        logic [SITE_W-1:0] pos;
    } t_site_ent;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_MOVE,
        ST_FIX,
        ST_CLR,
        ST_RDL,
        ST_RDE,
        ST_OUT
    } t_state;

endpackage

// ----- design/active_site_sparse_set.sv -----
// From request accept to result valid: range errors and unknown actions go straight
// to the output state; mark, set_degree and a plain unmark pass through EVAL; an unmark
// that moves the last list entry passes EVAL, MOVE and FIX; read_entry passes RDL and RDE.
// One request at a time; each step is a registered read of the site or list memory.
// clear_to_static sweeps all 4096 site words, one per cycle. Synchronous reset; after
// reset a clearing pass zeroes all 4096 site words before requests are taken.
module active_site_sparse_set
    import asss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    // memories
    t_site_ent         site_mem [MAX_SITES];
    logic [SITE_W-1:0] list_mem [MAX_SITES];

    t_site_ent         r_sm_rdata;
    logic [SITE_W-1:0] r_lm_rdata;

    logic              sm_we;
    logic [SITE_W-1:0] sm_waddr;
    t_site_ent         sm_wdata;
    logic [SITE_W-1:0] sm_raddr;
    logic              lm_we;
    logic [SITE_W-1:0] lm_waddr;
    logic [SITE_W-1:0] lm_wdata;
    logic [SITE_W-1:0] lm_raddr;

    // control and config registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_len, n_len;
    t_req              r_req, n_req;
    t_rsp              r_res, n_res;
    logic              r_in_range, n_in_range;
    logic [SITE_W-1:0] r_pos_idx, n_pos_idx;
    logic [SITE_W-1:0] r_moved, n_moved;
    logic [CNT_W-1:0]  r_site_count;
    logic [7:0]        r_bulk_thr;
    logic              r_ovalid;
    t_rsp              r_odata;

    logic              fire;
    logic              out_load;
    logic [CNT_W-1:0]  site_n;
    logic              req_in_range;
    t_site_ent         ent;
    t_site_ent         new_ent;
    logic [CNT_W-1:0]  last;

    assign fire       = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign site_n     = (r_site_count > CNT_W'(MAX_SITES)) ? CNT_W'(MAX_SITES) : r_site_count;
    assign req_in_range = ({1'b0, i_in_data.site} < site_n);
    assign ent        = r_sm_rdata;
    assign last       = r_len - CNT_W'(1);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            site_mem[sm_waddr] <= sm_wdata;
        end
        r_sm_rdata <= site_mem[sm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            list_mem[lm_waddr] <= lm_wdata;
        end
        r_lm_rdata <= list_mem[lm_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_count <= SITE_COUNT_RST;
            r_bulk_thr   <= BULK_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SITE_COUNT: r_site_count <= i_cfg_data;
                CFG_BULK_THR:   r_bulk_thr   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_idx   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
        end
    end

    // request payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_in_range <= n_in_range;
        r_pos_idx  <= n_pos_idx;
        r_moved    <= n_moved;
    end

    // result register
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= '{status:       r_res.status,
                         site_active:  r_res.site_active,
                         site_static:  r_res.site_static,
                         active_count: r_len,
                         listed_site:  r_res.listed_site};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // next state, memory control and result
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_len      = r_len;
        n_req      = r_req;
        n_res      = r_res;
        n_in_range = r_in_range;
        n_pos_idx  = r_pos_idx;
        n_moved    = r_moved;
        sm_we      = 1'b0;
        sm_waddr   = r_req.site;
        sm_wdata   = ent;
        sm_raddr   = i_in_data.site;
        lm_we      = 1'b0;
        lm_waddr   = r_len[SITE_W-1:0];
        lm_wdata   = r_req.site;
        lm_raddr   = i_in_data.position;
        new_ent    = ent;

        unique case (r_state)
            // zero the site memory after reset
            ST_INIT: begin
                sm_we    = 1'b1;
                sm_waddr = r_idx[SITE_W-1:0];
                sm_wdata = '0;
                if (r_idx == CNT_W'(MAX_SITES - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end

            ST_IDLE: begin
                if (fire) begin
                    n_req      = i_in_data;
                    n_res      = '0;
                    n_in_range = req_in_range;
                    priority case (i_in_data.action)
                        ACT_MARK, ACT_UNMARK, ACT_SETDEG: begin
                            if (!req_in_range) begin
                                n_res.status = STS_SITE_OR;
                                n_state      = ST_OUT;
                            end else begin
                                sm_raddr = i_in_data.site;
                                n_state  = ST_EVAL;
                            end
                        end
                        ACT_CLEAR: begin
                            n_len    = '0;
                            n_idx    = '0;
                            sm_raddr = '0;
                            n_state  = ST_CLR;
                        end
                        ACT_READ: begin
                            if ({1'b0, i_in_data.position} < r_len) begin
                                lm_raddr = i_in_data.position;
                                n_state  = ST_RDL;
                            end else begin
                                n_res.status = STS_POS_OR;
                                n_state      = ST_OUT;
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end

            // site word is back: modify and write it
            ST_EVAL: begin
                sm_we    = 1'b1;
                sm_waddr = r_req.site;
                n_state  = ST_OUT;
                priority case (r_req.action)
                    ACT_MARK: begin
                        new_ent.active = 1'b1;
                        if (!ent.listed && (r_len < CNT_W'(MAX_SITES))) begin
                            new_ent.listed = 1'b1;
                            new_ent.pos    = r_len[SITE_W-1:0];
                            lm_we          = 1'b1;
                            lm_waddr       = r_len[SITE_W-1:0];
                            lm_wdata       = r_req.site;
                            n_len          = r_len + CNT_W'(1);
                        end
                    end
                    ACT_UNMARK: begin
                        if (ent.active) begin
                            new_ent.active = 1'b0;
                            if (ent.listed && (r_len != '0)) begin
                                new_ent.listed = 1'b0;
                                n_len          = last;
                                // fill the hole with the last list entry
                                if (({1'b0, ent.pos} != last) && ({1'b0, ent.pos} < r_len)) begin
                                    lm_raddr  = last[SITE_W-1:0];
                                    n_pos_idx = ent.pos;
                                    n_state   = ST_MOVE;
                                end
                            end
                        end
                    end
                    default: begin
                        new_ent.stat_flag = (r_req.degree < r_bulk_thr);
                    end
                endcase
                sm_wdata          = new_ent;
                n_res.site_active = new_ent.active;
                n_res.site_static = new_ent.stat_flag;
            end

            // moved site is back from the list: relocate it, fetch its word
            ST_MOVE: begin
                lm_we    = 1'b1;
                lm_waddr = r_pos_idx;
                lm_wdata = r_lm_rdata;
                sm_raddr = r_lm_rdata;
                n_moved  = r_lm_rdata;
                n_state  = ST_FIX;
            end

            // point the moved site's reverse entry at its new slot
            ST_FIX: begin
                new_ent.pos = r_pos_idx;
                sm_we       = 1'b1;
                sm_waddr    = r_moved;
                sm_wdata    = new_ent;
                n_state     = ST_OUT;
            end

            // sweep: drop listed sites, re-add static sites below the site count in rising order
            ST_CLR: begin
                new_ent.listed = 1'b0;
                if (ent.listed) begin
                    new_ent.active = 1'b0;
                end
                if (({1'b0, r_idx[SITE_W-1:0]} < site_n) && ent.stat_flag) begin
                    new_ent.active = 1'b1;
                    new_ent.listed = 1'b1;
                    new_ent.pos    = r_len[SITE_W-1:0];
                    lm_we          = 1'b1;
                    lm_waddr       = r_len[SITE_W-1:0];
                    lm_wdata       = r_idx[SITE_W-1:0];
                    n_len          = r_len + CNT_W'(1);
                end
                sm_we    = 1'b1;
                sm_waddr = r_idx[SITE_W-1:0];
                sm_wdata = new_ent;
                if (r_in_range && (r_idx[SITE_W-1:0] == r_req.site)) begin
                    n_res.site_active = new_ent.active;
                    n_res.site_static = new_ent.stat_flag;
                end
                sm_raddr = r_idx[SITE_W-1:0] + SITE_W'(1);
                if (r_idx == CNT_W'(MAX_SITES - 1)) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end

            // read_entry: list word back, fetch the site's flags
            ST_RDL: begin
                n_res.listed_site = r_lm_rdata;
                sm_raddr          = r_lm_rdata;
                n_state           = ST_RDE;
            end

            ST_RDE: begin
                n_res.site_active = ent.active;
                n_res.site_static = ent.stat_flag;
                n_state           = ST_OUT;
            end

            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CNT_W'(MAX_SITES))
        else $error("list length above capacity");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == ST_OUT))
        else $error("result loaded outside the output state");

    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) && (r_idx != CNT_W'(MAX_SITES - 1))
            |=> (r_state == ST_CLR) && (r_idx == $past(r_idx) + CNT_W'(1)))
        else $error("clear sweep skipped a site");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!sm_we && !lm_we))
        else $error("memory write while idle");
`endif

endmodule
